[design/kbc_pkg.sv]
// ----------------------------------------------------------------------------
// kbc_pkg: shared types and constants of the keyboard text console
// Beat payloads, operation and scancode codes, cursor commands and the
// colour attribute table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kbc_pkg;

  localparam int TEXT_COLUMNS_DEF = 80;
  localparam int TEXT_ROWS_DEF    = 25;

  localparam int OP_W     = 2;
  localparam int SC_W     = 8;
  localparam int CELL_W   = 11;
  localparam int KIDX_W   = 7;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 11;
  localparam int COLOUR_W = 3;
  localparam int KEYMAP_DEPTH = 128;

  localparam logic [OP_W-1:0] OP_KEY  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

  localparam logic [SC_W-1:0] SC_BACKSPACE = 8'h0E;
  localparam logic [SC_W-1:0] SC_TAB       = 8'h0F;
  localparam logic [SC_W-1:0] SC_ENTER     = 8'h1C;
  localparam logic [SC_W-1:0] SC_UP        = 8'h48;
  localparam logic [SC_W-1:0] SC_LEFT      = 8'h4B;
  localparam logic [SC_W-1:0] SC_RIGHT     = 8'h4D;
  localparam logic [SC_W-1:0] SC_DOWN      = 8'h50;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] BLANK_ATTR = 8'h07;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic              data_ready;
    logic [SC_W-1:0]   scancode;
    logic [CELL_W-1:0] cell_index;
    logic [KIDX_W-1:0] keymap_index;
    logic [CHAR_W-1:0] keymap_value;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]    cursor_position;
    logic [COLOUR_W-1:0] colour_now;
    logic [CHAR_W-1:0]   read_char;
    logic [CHAR_W-1:0]   read_attr;
    logic                did_scroll;
  } out_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_UP,
    CUR_DOWN,
    CUR_LEFT,
    CUR_ADV,
    CUR_NEWLINE,
    CUR_HOME_LAST
  } cur_cmd_e;

  typedef struct packed {
    logic at_origin;
    logic past_end;
  } cur_stat_t;

  function automatic logic [CHAR_W-1:0] attr_of(input logic [COLOUR_W-1:0] colour);
    logic [CHAR_W-1:0] attr;
    unique case (colour)
      3'd0:    attr = 8'h07;
      3'd1:    attr = 8'h04;
      3'd2:    attr = 8'h02;
      3'd3:    attr = 8'h01;
      3'd4:    attr = 8'h0F;
      3'd5:    attr = 8'h0C;
      3'd6:    attr = 8'h0A;
      default: attr = 8'h09;
    endcase
    return attr;
  endfunction

endpackage

`default_nettype wire

[design/kbc_ram.sv]
// ----------------------------------------------------------------------------
// kbc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kbc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/kbc_cursor.sv]
// ----------------------------------------------------------------------------
// kbc_cursor: cursor tracker
// Holds row, column and row base address; applies one move per cycle and
// reports the linear cursor cell and its boundary status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kbc_cursor #(
  parameter int TEXT_COLUMNS = kbc_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = kbc_pkg::TEXT_ROWS_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire kbc_pkg::cur_cmd_e                            cmd_i,
  output logic [$clog2(TEXT_COLUMNS*TEXT_ROWS+1)-1:0]       cursor_o,
  output kbc_pkg::cur_stat_t                                stat_o
);

  import kbc_pkg::*;

  localparam int CW    = $clog2(TEXT_COLUMNS);
  localparam int RW    = $clog2(TEXT_ROWS + 1);
  localparam int CELLS = TEXT_COLUMNS * TEXT_ROWS;
  localparam int AW    = $clog2(CELLS + 1);

  localparam logic [CW-1:0] COL_LAST  = CW'(TEXT_COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(TEXT_ROWS - 1);
  localparam logic [RW-1:0] ROW_END   = RW'(TEXT_ROWS);
  localparam logic [AW-1:0] COLS_A    = AW'(TEXT_COLUMNS);
  localparam logic [AW-1:0] LAST_BASE = AW'((TEXT_ROWS - 1) * TEXT_COLUMNS);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] base_up, base_dn;

  assign base_up = base_q - COLS_A;
  assign base_dn = base_q + COLS_A;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    unique case (cmd_i)
      CUR_UP: begin
        if (row_q != '0) begin
          row_d  = row_q - RW'(1);
          base_d = base_up;
        end
      end
      CUR_DOWN: begin
        if (row_q < ROW_LAST) begin
          row_d  = row_q + RW'(1);
          base_d = base_dn;
        end
      end
      CUR_LEFT: begin
        if (col_q != '0) begin
          col_d = col_q - CW'(1);
        end else if (row_q != '0) begin
          col_d  = COL_LAST;
          row_d  = row_q - RW'(1);
          base_d = base_up;
        end
      end
      CUR_ADV: begin
        if (col_q == COL_LAST) begin
          col_d  = '0;
          row_d  = row_q + RW'(1);
          base_d = base_dn;
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      CUR_NEWLINE: begin
        col_d  = '0;
        row_d  = row_q + RW'(1);
        base_d = base_dn;
      end
      CUR_HOME_LAST: begin
        col_d  = '0;
        row_d  = ROW_LAST;
        base_d = LAST_BASE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

  assign cursor_o         = base_q + AW'(col_q);
  assign stat_o.at_origin = (base_q == '0) && (col_q == '0);
  assign stat_o.past_end  = (row_q == ROW_END);

endmodule

`default_nettype wire

[design/keyboard_text_console_core.sv]
// ----------------------------------------------------------------------------
// keyboard_text_console_core: keyboard driven text console
// Sequencer over a cell RAM, a keymap RAM and a cursor tracker.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_i) takes one operation per beat:
//   key event, screen cell read or keymap load. out channel
//   (out_valid_o/out_ready_i/out_o) returns exactly one result beat for
//   every input beat, in order.
//   After reset the cell RAM is swept to blank cells, one cell per cycle;
//   in_ready_o stays low during that sweep. The cursor and colour reset
//   to zero.
//   One beat at a time: in_ready_o drops after a beat is taken and rises
//   again once its result sits in the output register.
//   A key that scrolls copies the screen one cell per cycle through the cell
//   RAM port pair and then blanks the last row.
//   A stalled receiver holds out_o; one further beat may be taken and
//   processed, its result waiting until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyboard_text_console_core #(
  parameter int TEXT_COLUMNS = kbc_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = kbc_pkg::TEXT_ROWS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire kbc_pkg::in_t in_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output kbc_pkg::out_t     out_o
);

  import kbc_pkg::*;

  localparam int CELLS = TEXT_COLUMNS * TEXT_ROWS;
  localparam int MAW   = $clog2(CELLS);
  localparam int AW    = $clog2(CELLS + 1);
  localparam int EW    = AW + CELL_W;
  localparam int WW    = 2 * CHAR_W;

  localparam logic [AW-1:0]  CELLS_A    = AW'(CELLS);
  localparam logic [AW-1:0]  COLS_A     = AW'(TEXT_COLUMNS);
  localparam logic [EW-1:0]  CELLS_E    = EW'(CELLS);
  localparam logic [MAW-1:0] CLEAR_LAST = MAW'(CELLS - 1);
  localparam logic [MAW-1:0] COPY_LAST  = MAW'(CELLS - TEXT_COLUMNS - 1);
  localparam logic [WW-1:0]  BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_MAP,
    ST_ADV,
    ST_BLANK,
    ST_CHECK,
    ST_COPY,
    ST_CLRLINE,
    ST_RESP
  } state_e;

  state_e              state_q;
  in_t                 item_q;
  logic [MAW-1:0]      idx_q;
  logic [AW-1:0]       rd_q;
  logic                rd_pend_q;
  logic [COLOUR_W-1:0] colour_q;
  logic [CHAR_W-1:0]   rchar_q;
  logic [CHAR_W-1:0]   rattr_q;
  logic                scrolled_q;
  out_t                out_q;
  logic                out_valid_q;

  cur_cmd_e            cur_cmd;
  cur_stat_t           cur_stat;
  logic [AW-1:0]       cursor;
  logic [EW-1:0]       cursor_ext;
  logic [EW-1:0]       cell_ext;
  logic                cell_ok;
  logic                key_ok;
  logic                copy_rd;

  logic                scr_we;
  logic [MAW-1:0]      scr_waddr;
  logic [WW-1:0]       scr_wdata;
  logic                scr_re;
  logic [MAW-1:0]      scr_raddr;
  logic [WW-1:0]       scr_rdata;
  logic                km_we;
  logic                km_re;
  logic [CHAR_W-1:0]   km_rdata;

  assign cell_ext   = EW'(item_q.cell_index);
  assign cell_ok    = cell_ext < CELLS_E;
  assign cursor_ext = EW'(cursor);
  assign key_ok     = (item_q.operation == OP_KEY) && item_q.data_ready &&
                      !item_q.scancode[SC_W-1];
  assign copy_rd    = rd_q < CELLS_A;

  always_comb begin
    cur_cmd   = CUR_HOLD;
    scr_we    = 1'b0;
    scr_waddr = idx_q;
    scr_wdata = BLANK_CELL;
    scr_re    = 1'b0;
    scr_raddr = rd_q[MAW-1:0];
    km_we     = 1'b0;
    km_re     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        scr_we = 1'b1;
      end
      ST_DECODE: begin
        if (item_q.operation == OP_READ) begin
          scr_re    = cell_ok;
          scr_raddr = cell_ext[MAW-1:0];
        end
        km_we = (item_q.operation == OP_LOAD);
        if (key_ok) begin
          unique case (item_q.scancode)
            SC_TAB: begin
            end
            SC_BACKSPACE: begin
              if (!cur_stat.at_origin) begin
                cur_cmd = CUR_LEFT;
              end
            end
            SC_ENTER: cur_cmd = CUR_NEWLINE;
            SC_UP:    cur_cmd = CUR_UP;
            SC_DOWN:  cur_cmd = CUR_DOWN;
            SC_LEFT:  cur_cmd = CUR_LEFT;
            SC_RIGHT: cur_cmd = CUR_ADV;
            default:  km_re   = 1'b1;
          endcase
        end
      end
      ST_MAP: begin
        scr_we    = 1'b1;
        scr_waddr = cursor[MAW-1:0];
        scr_wdata = {attr_of(colour_q), km_rdata};
      end
      ST_ADV: begin
        cur_cmd = CUR_ADV;
      end
      ST_BLANK: begin
        scr_we    = 1'b1;
        scr_waddr = cursor[MAW-1:0];
      end
      ST_CHECK: begin
        if (cur_stat.past_end) begin
          cur_cmd = CUR_HOME_LAST;
        end
      end
      ST_COPY: begin
        scr_re    = copy_rd;
        scr_we    = rd_pend_q;
        scr_wdata = scr_rdata;
      end
      ST_CLRLINE: begin
        scr_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      item_q      <= '0;
      idx_q       <= '0;
      rd_q        <= '0;
      rd_pend_q   <= 1'b0;
      colour_q    <= '0;
      rchar_q     <= '0;
      rattr_q     <= '0;
      scrolled_q  <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          idx_q <= idx_q + MAW'(1);
          if (idx_q == CLEAR_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q     <= in_i;
            rchar_q    <= '0;
            rattr_q    <= '0;
            scrolled_q <= 1'b0;
            state_q    <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          state_q <= ST_RESP;
          if (item_q.operation == OP_READ) begin
            if (cell_ok) begin
              state_q <= ST_READ;
            end
          end else if (key_ok) begin
            unique case (item_q.scancode)
              SC_TAB: colour_q <= colour_q + COLOUR_W'(1);
              SC_BACKSPACE: begin
                if (!cur_stat.at_origin) begin
                  state_q <= ST_BLANK;
                end
              end
              SC_ENTER, SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT: state_q <= ST_CHECK;
              default: state_q <= ST_MAP;
            endcase
          end
        end
        ST_READ: begin
          rchar_q <= scr_rdata[CHAR_W-1:0];
          rattr_q <= scr_rdata[WW-1:CHAR_W];
          state_q <= ST_RESP;
        end
        ST_MAP: begin
          state_q <= ST_ADV;
        end
        ST_ADV: begin
          state_q <= ST_CHECK;
        end
        ST_BLANK: begin
          state_q <= ST_RESP;
        end
        ST_CHECK: begin
          if (cur_stat.past_end) begin
            scrolled_q <= 1'b1;
            idx_q      <= '0;
            rd_q       <= COLS_A;
            rd_pend_q  <= 1'b0;
            state_q    <= ST_COPY;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_COPY: begin
          rd_pend_q <= copy_rd;
          if (copy_rd) begin
            rd_q <= rd_q + AW'(1);
          end
          if (rd_pend_q) begin
            idx_q <= idx_q + MAW'(1);
            if (idx_q == COPY_LAST) begin
              rd_pend_q <= 1'b0;
              state_q   <= ST_CLRLINE;
            end
          end
        end
        ST_CLRLINE: begin
          idx_q <= idx_q + MAW'(1);
          if (idx_q == CLEAR_LAST) begin
            idx_q   <= '0;
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.cursor_position <= cursor_ext[POS_W-1:0];
            out_q.colour_now      <= colour_q;
            out_q.read_char       <= rchar_q;
            out_q.read_attr       <= rattr_q;
            out_q.did_scroll      <= scrolled_q;
            out_valid_q           <= 1'b1;
            state_q               <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  kbc_cursor #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS)
  ) u_cursor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cur_cmd),
    .cursor_o(cursor),
    .stat_o  (cur_stat)
  );

  kbc_ram #(
    .WIDTH(WW),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (scr_we),
    .waddr_i(scr_waddr),
    .wdata_i(scr_wdata),
    .re_i   (scr_re),
    .raddr_i(scr_raddr),
    .rdata_o(scr_rdata)
  );

  kbc_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(KEYMAP_DEPTH)
  ) u_keymap (
    .clk_i  (clk_i),
    .we_i   (km_we),
    .waddr_i(item_q.keymap_index),
    .wdata_i(item_q.keymap_value),
    .re_i   (km_re),
    .raddr_i(item_q.scancode[KIDX_W-1:0]),
    .rdata_o(km_rdata)
  );

endmodule

`default_nettype wire

[design/kbc_checker.sv]
// ----------------------------------------------------------------------------
// kbc_checker: port level checks of the keyboard text console
// Watches the channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kbc_checker #(
  parameter int TEXT_COLUMNS = kbc_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = kbc_pkg::TEXT_ROWS_DEF
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire kbc_pkg::out_t out_o
);

  import kbc_pkg::*;

  localparam logic [POS_W-1:0] LAST_ROW_POS = POS_W'((TEXT_ROWS - 1) * TEXT_COLUMNS);

  // one beat in flight
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result beat changed");

  a_scroll_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.did_scroll |-> out_o.cursor_position == LAST_ROW_POS)
    else $error("scroll left cursor off last row start");

  a_scroll_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.did_scroll |-> out_o.read_char == '0 && out_o.read_attr == '0)
    else $error("scroll beat carries read data");

endmodule

bind keyboard_text_console_core kbc_checker #(
  .TEXT_COLUMNS(TEXT_COLUMNS),
  .TEXT_ROWS   (TEXT_ROWS)
) u_kbc_checker (.*);

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for keyboard_text_console_core
// A short table of directed beats, then random key, read and keymap traffic
// built so the cursor reaches the bottom row and keeps scrolling the screen.
// Beats are checked in order, field by field, against an in-bench console
// model or a pinned table value, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import kbc_pkg::*;

  localparam int COLS  = TEXT_COLUMNS_DEF;
  localparam int ROWS  = TEXT_ROWS_DEF;
  localparam int CELLS = COLS * ROWS;
  localparam int LAST_ROW_START = (ROWS - 1) * COLS;

  localparam int RANDOM_BEATS = 300;
  localparam int CALM_BEATS   = 40;
  localparam int HOLD_CYCLES  = 2500;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT        = 3_000_000;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [15:0] BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};
  localparam logic [63:0] COLOUR_ATTRS = 64'h09_0A_0C_0F_01_02_04_07;

  localparam out_t HOME_BLANK = '{11'd0, 3'd0, BLANK_CHAR, BLANK_ATTR, 1'b0};
  localparam out_t HOME_ZERO  = '0;

  typedef struct {
    in_t  beat;
    bit   pinned;
    out_t want;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_beat   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_beat;

  keyboard_text_console_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_beat)
  );

  always #1 clk = ~clk;

  // console model state
  int          pred_cursor;
  logic [2:0]  pred_colour;
  logic [15:0] screen_mem [CELLS];
  logic [7:0]  keymap_mem [KEYMAP_DEPTH];
  bit          keymap_loaded [KEYMAP_DEPTH];
  out_t        pending_results [$];
  dir_row_t    dir_rows [$];

  int mismatches = 0;
  int cycle_count = 0;
  int n_beats = 0, n_counted = 0, n_keys = 0, n_scrolls = 0;
  int n_reads = 0, n_loads = 0, n_ignored = 0, n_holds = 0;
  int tx_rate = 0, rx_rate = 0;
  int hold_seq = 0, hold_seen = 0, hold_left = 0, stall_left = 0;
  logic calm = 1'b0;

  function automatic bit press_key(logic [7:0] sc);
    int c;
    int i;
    bit scrolled;
    c = pred_cursor;
    scrolled = 1'b0;
    case (sc)
      SC_TAB: pred_colour = pred_colour + 3'd1;
      SC_BACKSPACE: begin
        if (c > 0) begin
          c--;
          screen_mem[c] = BLANK_CELL;
        end
      end
      SC_ENTER: c = c + COLS - c % COLS;
      SC_UP:    if (c >= COLS) c -= COLS;
      SC_DOWN:  if (c < CELLS - COLS) c += COLS;
      SC_LEFT:  if (c > 0) c--;
      SC_RIGHT: begin
        if (c < CELLS - 1) c++;
        else c = c + COLS - c % COLS;
      end
      default: begin
        screen_mem[c] = {COLOUR_ATTRS[pred_colour*8 +: 8], keymap_mem[sc[6:0]]};
        c++;
      end
    endcase
    if (c >= CELLS) begin
      for (i = 0; i < CELLS - COLS; i++) screen_mem[i] = screen_mem[i + COLS];
      for (i = CELLS - COLS; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
      c = LAST_ROW_START;
      scrolled = 1'b1;
    end
    pred_cursor = c;
    return scrolled;
  endfunction

  function automatic out_t console_step(in_t b);
    out_t r;
    r = '0;
    case (b.operation)
      OP_KEY: begin
        if (b.data_ready && !b.scancode[7]) r.did_scroll = press_key(b.scancode);
      end
      OP_READ: begin
        if (int'(b.cell_index) < CELLS) begin
          r.read_char = screen_mem[b.cell_index][7:0];
          r.read_attr = screen_mem[b.cell_index][15:8];
        end
      end
      OP_LOAD: keymap_mem[b.keymap_index] = b.keymap_value;
      default: ;
    endcase
    r.cursor_position = 11'(pred_cursor);
    r.colour_now = pred_colour;
    return r;
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    mismatches++;
  endfunction

  function automatic void take_result(out_t got);
    out_t w;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
      mismatches++;
    end else begin
      w = pending_results.pop_front();
      if (got.cursor_position !== w.cursor_position)
        note_mismatch("cursor_position", w.cursor_position, got.cursor_position);
      if (got.colour_now !== w.colour_now)
        note_mismatch("colour_now", w.colour_now, got.colour_now);
      if (got.read_char !== w.read_char)
        note_mismatch("read_char", w.read_char, got.read_char);
      if (got.read_attr !== w.read_attr)
        note_mismatch("read_attr", w.read_attr, got.read_attr);
      if (got.did_scroll !== w.did_scroll)
        note_mismatch("did_scroll", w.did_scroll, got.did_scroll);
    end
  endfunction

  function automatic void add_row(logic [OP_W-1:0] op, logic rdy, logic [SC_W-1:0] sc,
                                  logic [CELL_W-1:0] cell_idx, logic [KIDX_W-1:0] kidx,
                                  logic [CHAR_W-1:0] kval, bit pinned, out_t want);
    dir_row_t r;
    r.beat.operation    = op;
    r.beat.data_ready   = rdy;
    r.beat.scancode     = sc;
    r.beat.cell_index   = cell_idx;
    r.beat.keymap_index = kidx;
    r.beat.keymap_value = kval;
    r.pinned = pinned;
    r.want   = want;
    dir_rows.push_back(r);
  endfunction

  task automatic send(in_t b, bit pinned, out_t want);
    out_t predicted;
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = console_step(b);
    pending_results.push_back(pinned ? want : predicted);
    n_beats++;
    if (b.operation == OP_LOAD) begin
      keymap_loaded[b.keymap_index] = 1'b1;
      n_loads++;
      n_counted++;
    end else if (b.operation == OP_READ) begin
      n_reads++;
      n_counted++;
    end else if (b.operation == OP_KEY && b.data_ready && !b.scancode[7]) begin
      n_keys++;
      n_counted++;
      if (predicted.did_scroll) n_scrolls++;
    end else begin
      n_ignored++;
    end
    if (n_beats % 32 == 0) tx_rate = $urandom_range(0, 3);
    if (!calm && tx_rate != 0 && $urandom_range(0, 7) < tx_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // typed key; loads its keymap slot first when still unloaded
  task automatic send_typed(in_t b);
    in_t ld;
    logic [7:0] sc;
    sc = 8'($urandom_range(0, 127));
    if (!(sc inside {SC_TAB, SC_BACKSPACE, SC_ENTER, SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT})
        && !keymap_loaded[sc[6:0]]) begin
      ld = b;
      ld.operation    = OP_LOAD;
      ld.keymap_index = sc[6:0];
      ld.keymap_value = 8'($urandom);
      send(ld, 1'b0, '0);
    end
    b.operation  = OP_KEY;
    b.data_ready = 1'b1;
    b.scancode   = sc;
    send(b, 1'b0, '0);
  endtask

  task automatic random_beat();
    in_t b;
    int pick;
    int cell_sel;
    b.operation    = OP_KEY;
    b.data_ready   = 1'b1;
    b.scancode     = 8'($urandom);
    b.cell_index   = 11'($urandom);
    b.keymap_index = 7'($urandom);
    b.keymap_value = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      b.operation = OP_LOAD;
      send(b, 1'b0, '0);
    end else if (pick < 20) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          cell_sel = pred_cursor - int'($urandom_range(0, 3));
          if (cell_sel < 0) cell_sel = 0;
        end
        2:       cell_sel = $urandom_range(0, CELLS - 1);
        default: cell_sel = $urandom_range(CELLS, 2047);
      endcase
      b.operation  = OP_READ;
      b.cell_index = 11'(cell_sel);
      send(b, 1'b0, '0);
    end else if (pick < 26) begin
      case ($urandom_range(0, 2))
        0:       b.data_ready = 1'b0;
        1:       b.scancode[7] = 1'b1;
        default: b.operation = OP_UNUSED;
      endcase
      send(b, 1'b0, '0);
    end else if (pred_cursor == LAST_ROW_START && pick < 45) begin
      // walk to the very last cell, then push past it
      b.scancode = SC_LEFT;
      send(b, 1'b0, '0);
      b.scancode = SC_DOWN;
      send(b, 1'b0, '0);
      if ($urandom_range(0, 1) == 0) begin
        b.scancode = SC_RIGHT;
        send(b, 1'b0, '0);
      end else begin
        send_typed(b);
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        send_typed(b);
      end else begin
        if (pick < 60)      b.scancode = SC_ENTER;
        else if (pick < 70) b.scancode = SC_DOWN;
        else if (pick < 75) b.scancode = SC_UP;
        else if (pick < 81) b.scancode = SC_LEFT;
        else if (pick < 87) b.scancode = SC_RIGHT;
        else if (pick < 94) b.scancode = SC_BACKSPACE;
        else                b.scancode = SC_TAB;
        send(b, 1'b0, '0);
      end
    end
  endtask

  // receiver: result check, random stalls and long hold-offs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("%0t: no progress within %0d cycles", $time, LIMIT);
      $display("Regression FAIL");
      $finish;
    end
    if (out_valid && out_ready) take_result(out_beat);
    if (cycle_count % 256 == 0) rx_rate <= $urandom_range(0, 3);
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && rx_rate != 0 && $urandom_range(0, 7) < rx_rate) begin
      stall_left <= $urandom_range(1, 6) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int i;
    pred_cursor = 0;
    pred_colour = '0;
    for (i = 0; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
    for (i = 0; i < KEYMAP_DEPTH; i++) begin
      keymap_mem[i] = '0;
      keymap_loaded[i] = 1'b0;
    end

    add_row(OP_READ,   1'b0, 8'h00, 11'd0,    7'd0,   8'h00, 1'b1, HOME_BLANK);
    add_row(OP_READ,   1'b0, 8'h00, 11'd1999, 7'd0,   8'h00, 1'b1, HOME_BLANK);
    add_row(OP_READ,   1'b0, 8'h00, 11'd2047, 7'd0,   8'h00, 1'b1, HOME_ZERO);
    add_row(OP_READ,   1'b0, 8'h00, 11'd2000, 7'd0,   8'h00, 1'b1, HOME_ZERO);
    add_row(OP_UNUSED, 1'b1, 8'hFF, 11'h7FF,  7'h7F,  8'hFF, 1'b1, HOME_ZERO);
    add_row(OP_KEY,    1'b0, SC_ENTER, 11'd0, 7'd0,   8'h00, 1'b1, HOME_ZERO);
    add_row(OP_KEY,    1'b1, 8'hFF, 11'd0,    7'd0,   8'h00, 1'b1, HOME_ZERO);
    add_row(OP_KEY,    1'b1, SC_ENTER | 8'h80, 11'd0, 7'd0, 8'h00, 1'b1, HOME_ZERO);
    add_row(OP_KEY,    1'b1, SC_BACKSPACE, 11'd0, 7'd0, 8'h00, 1'b1, HOME_ZERO);
    add_row(OP_KEY,    1'b1, SC_LEFT, 11'd0,  7'd0,   8'h00, 1'b1, HOME_ZERO);
    add_row(OP_KEY,    1'b1, SC_UP,   11'd0,  7'd0,   8'h00, 1'b1, HOME_ZERO);
    add_row(OP_LOAD,   1'b0, 8'h00, 11'd0,    7'd0,   8'h00, 1'b1, HOME_ZERO);
    add_row(OP_LOAD,   1'b0, 8'h00, 11'd0,    7'h7F,  8'hFF, 1'b1, HOME_ZERO);
    add_row(OP_LOAD,   1'b0, 8'h00, 11'd0,    7'h1E,  8'h61, 1'b0, '0);
    add_row(OP_KEY,    1'b1, 8'h00, 11'd0,    7'd0,   8'h00, 1'b0, '0);
    add_row(OP_KEY,    1'b1, 8'h7F, 11'd0,    7'd0,   8'h00, 1'b0, '0);
    add_row(OP_KEY,    1'b1, SC_TAB, 11'd0,   7'd0,   8'h00, 1'b0, '0);
    add_row(OP_KEY,    1'b1, 8'h1E, 11'd0,    7'd0,   8'h00, 1'b0, '0);
    add_row(OP_READ,   1'b0, 8'h00, 11'd1,    7'd0,   8'h00, 1'b0, '0);
    add_row(OP_READ,   1'b0, 8'h00, 11'd2,    7'd0,   8'h00, 1'b0, '0);
    add_row(OP_KEY,    1'b1, SC_RIGHT, 11'd0, 7'd0,   8'h00, 1'b0, '0);
    add_row(OP_KEY,    1'b1, SC_DOWN,  11'd0, 7'd0,   8'h00, 1'b0, '0);
    add_row(OP_KEY,    1'b1, SC_ENTER, 11'd0, 7'd0,   8'h00, 1'b0, '0);
    add_row(OP_KEY,    1'b1, SC_BACKSPACE, 11'd0, 7'd0, 8'h00, 1'b0, '0);
    add_row(OP_READ,   1'b0, 8'h00, 11'd0,    7'd0,   8'h00, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].want);

    n_counted = 0;
    while (n_counted < RANDOM_BEATS) begin
      if (n_counted >= RANDOM_BEATS - CALM_BEATS) calm <= 1'b1;
      // long receiver hold-off so the block fills up and stalls its input
      if (n_holds < 2 && n_counted >= 120 * (n_holds + 1)) begin
        hold_seq <= hold_seq + 1;
        n_holds++;
      end
      random_beat();
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d beats: %0d key presses (%0d scrolls), %0d cell reads, %0d keymap loads",
             n_beats, n_keys, n_scrolls, n_reads, n_loads);
    $display("%0d ignored beats, %0d receiver hold-offs, %0d mismatches",
             n_ignored, n_holds, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
